// File: rtl/smac_pkg.sv
`default_nettype none
package smac_pkg;

	localparam int unsigned DATA_W  = 32;
	localparam int unsigned COUNT_W = 5;

	typedef enum logic [1:0] {
		OP_PUSH       = 2'd0,
		OP_POP        = 2'd1,
		OP_REMOVE_MID = 2'd2,
		OP_PEEK       = 2'd3
	} op_t;

	// middle value reported for an empty stack
	localparam logic signed [DATA_W-1:0] MID_EMPTY = '1;

	typedef struct packed {
		logic                     valid;
		op_t                      op;
		logic signed [DATA_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] middle_value;
		logic [COUNT_W-1:0]       count;
		logic                     empty_res;
		logic                     rejected;
	} res_t;

endpackage
`default_nettype wire

// File: rtl/smac_stack.sv
`default_nettype none
module smac_stack
	import smac_pkg::*;
#(
	parameter int unsigned DEPTH = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cmd_t cmd,
	output res_t      res
);

	localparam int unsigned OW = $clog2(DEPTH + 1);
	localparam int unsigned IW = $clog2(DEPTH);

	logic [DATA_W-1:0] cells_q [DEPTH];
	logic [OW-1:0]     occ_q;

	logic          full;
	logic          empty;
	logic          push_ok;
	logic          pop_ok;
	logic          rm_ok;
	logic          rej;
	logic [OW-1:0] occ_next;
	logic [OW-1:0] occ_m1;
	logic [OW-1:0] occ_next_m1;
	logic [IW-1:0] mid_old;
	logic [IW-1:0] mid_new;
	logic [IW-1:0] rd_idx;

	assign full  = (occ_q == OW'(DEPTH));
	assign empty = (occ_q == '0);

	always_comb begin
		push_ok = 1'b0;
		pop_ok  = 1'b0;
		rm_ok   = 1'b0;
		rej     = 1'b0;
		unique case (cmd.op)
			OP_PUSH: begin
				push_ok = !full;
				rej     = full;
			end
			OP_POP: begin
				pop_ok = !empty;
				rej    = empty;
			end
			OP_REMOVE_MID: begin
				rm_ok = !empty;
				rej   = empty;
			end
			OP_PEEK: begin
				rej = 1'b0;
			end
			default: begin
				rej = 1'b0;
			end
		endcase
	end

	always_comb begin
		occ_next = occ_q;
		if (push_ok) begin
			occ_next = occ_q + OW'(1);
		end else if (pop_ok || rm_ok) begin
			occ_next = occ_q - OW'(1);
		end
	end

	assign occ_m1      = occ_q - OW'(1);
	assign occ_next_m1 = occ_next - OW'(1);
	assign mid_old     = IW'(occ_m1 >> 1);
	assign mid_new     = IW'(occ_next_m1 >> 1);

	// after a removal everything at or above the old middle came from one place up
	assign rd_idx = (rm_ok && (mid_new >= mid_old)) ? mid_new + IW'(1) : mid_new;

	always_comb begin
		res.count     = COUNT_W'(occ_next);
		res.empty_res = (occ_next == '0);
		res.rejected  = rej;
		if (occ_next == '0) begin
			res.middle_value = MID_EMPTY;
		end else if (push_ok && empty) begin
			res.middle_value = cmd.value;
		end else begin
			res.middle_value = cells_q[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (cmd.valid) begin
			occ_q <= occ_next;
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic shift_in;
		logic [DATA_W-1:0] upper;
		if (i + 1 < DEPTH) begin : g_up
			assign upper = cells_q[i+1];
		end else begin : g_top
			assign upper = cells_q[i];
		end
		assign shift_in = rm_ok && (IW'(i) >= mid_old) && (OW'(i + 1) < occ_q);

		always_ff @(posedge clk) begin
			if (cmd.valid) begin
				if (push_ok && (OW'(i) == occ_q)) begin
					cells_q[i] <= cmd.value;
				end else if (shift_in) begin
					cells_q[i] <= upper;
				end
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/stack_with_middle_access_core.sv
`default_nettype none
// Bounded stack of signed 32-bit values with push, pop, remove-middle and peek.
// The middle entry, counted from the bottom, sits at index (count-1)/2. Every
// accepted beat gives exactly one result beat: the middle value after the
// operation (all ones when empty), the count, an empty flag, and a rejected
// flag for a push on a full stack or a pop/remove on an empty one. One beat
// can be taken every cycle while out_ready does not stall the output; a result
// passes through the input register, then the result register. The rate rests
// on updating the occupancy counter and shifting the entry cells in parallel.
module stack_with_middle_access_core
	import smac_pkg::*;
#(
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic [1:0]               op,
	input  wire logic signed [DATA_W-1:0] value,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic signed [DATA_W-1:0]      middle_value,
	output logic [COUNT_W-1:0]            count,
	output logic                          empty_res,
	output logic                          rejected
);

	logic                     valid_s1;
	op_t                      op_s1;
	logic signed [DATA_W-1:0] value_s1;
	logic                     out_valid_q;
	res_t                     res_q;
	logic                     advance;
	cmd_t                     cmd;
	res_t                     res;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1    <= op_t'(op);
			value_s1 <= value;
		end
	end

	assign cmd.valid = advance;
	assign cmd.op    = op_s1;
	assign cmd.value = value_s1;

	smac_stack #(
		.DEPTH(DEPTH)
	) u_stack (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.res   (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign middle_value = res_q.middle_value;
	assign count        = res_q.count;
	assign empty_res    = res_q.empty_res;
	assign rejected     = res_q.rejected;

	a_empty_reports: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && empty_res) |-> (middle_value == MID_EMPTY && count == '0))
		else $error("empty result without all-ones middle or zero count");

	a_reject_edge: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && rejected && !empty_res) |-> (count == COUNT_W'(DEPTH)))
		else $error("rejection on a stack that is neither empty nor full");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid)
		else $error("stage beat advanced but no result beat appeared");

endmodule
`default_nettype wire

// File: tb/stack_with_middle_access_core_tb.sv
module stack_with_middle_access_core_tb;
	import smac_pkg::*;

	localparam int unsigned STACK_DEPTH = 16;
	localparam int unsigned HOLD_CYCLES = 120;
	localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

	// mirror of the stack contents, keeps the results still owed by the block
	class stack_mirror;
		logic signed [DATA_W-1:0] cells [STACK_DEPTH];
		int unsigned fill;
		res_t owed[$];
		int unsigned mismatches;

		function new();
			fill = 0;
			mismatches = 0;
		endfunction

		function void apply_op(op_t beat_op, logic signed [DATA_W-1:0] beat_value);
			res_t r;
			bit rej;
			int unsigned i;
			rej = 1'b0;
			case (beat_op)
				OP_PUSH: begin
					if (fill >= STACK_DEPTH) rej = 1'b1;
					else begin
						cells[fill] = beat_value;
						fill++;
					end
				end
				OP_POP: begin
					if (fill == 0) rej = 1'b1;
					else fill--;
				end
				OP_REMOVE_MID: begin
					if (fill == 0) rej = 1'b1;
					else begin
						// close the gap left by the middle entry
						for (i = (fill - 1) / 2; i + 1 < fill; i++)
							cells[i] = cells[i + 1];
						fill--;
					end
				end
				default: ;
			endcase
			r.middle_value = (fill == 0) ? MID_EMPTY : cells[(fill - 1) / 2];
			r.count        = COUNT_W'(fill);
			r.empty_res    = (fill == 0);
			r.rejected     = rej;
			owed.push_back(r);
		endfunction

		function void check_result(logic signed [DATA_W-1:0] mv, logic [COUNT_W-1:0] cnt,
				logic emp, logic rej);
			res_t exp_res;
			if (owed.size() == 0) begin
				$error("result beat with nothing outstanding");
				mismatches++;
				return;
			end
			exp_res = owed.pop_front();
			if (mv !== exp_res.middle_value) begin
				$error("middle_value mismatch: expected %0d, actual %0d",
					exp_res.middle_value, mv);
				mismatches++;
			end
			if (cnt !== exp_res.count) begin
				$error("count mismatch: expected %0d, actual %0d", exp_res.count, cnt);
				mismatches++;
			end
			if (emp !== exp_res.empty_res) begin
				$error("empty_res mismatch: expected %0b, actual %0b", exp_res.empty_res, emp);
				mismatches++;
			end
			if (rej !== exp_res.rejected) begin
				$error("rejected mismatch: expected %0b, actual %0b", exp_res.rejected, rej);
				mismatches++;
			end
		endfunction

		function int unsigned outstanding();
			return owed.size();
		endfunction
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic [1:0]               op = 2'd0;
	logic signed [DATA_W-1:0] value = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic signed [DATA_W-1:0] middle_value;
	logic [COUNT_W-1:0]       count;
	logic                     empty_res;
	logic                     rejected;

	stack_mirror mirror;
	int unsigned tx_idle_pct = 36;
	int unsigned rx_idle_pct = 36;
	bit          hold_req = 1'b0;

	stack_with_middle_access_core #(
		.DEPTH(STACK_DEPTH)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.value       (value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.middle_value(middle_value),
		.count       (count),
		.empty_res   (empty_res),
		.rejected    (rejected)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#(12 * 400000);
		$display("Regression FAIL");
		$finish;
	end

	// receiver: random back-pressure, or a long hold-off on request
	initial begin
		int unsigned n;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				for (n = 0; n < HOLD_CYCLES; n++) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			mirror.check_result(middle_value, count, empty_res, rejected);
	end

	task automatic send_beat(op_t beat_op, logic signed [DATA_W-1:0] beat_value);
		while ($urandom_range(99) < tx_idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		op       <= beat_op;
		value    <= beat_value;
		do @(posedge clk); while (!in_ready);
		mirror.apply_op(beat_op, beat_value);
	endtask

	task automatic release_input();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		release_input();
		while (mirror.outstanding() != 0) @(posedge clk);
	endtask

	function automatic logic signed [DATA_W-1:0] pick_value();
		if ($urandom_range(7) == 0) begin
			case ($urandom_range(3))
				0: return VAL_MIN;
				1: return VAL_MAX;
				2: return '0;
				default: return '1;
			endcase
		end
		return $urandom;
	endfunction

	// runs of fill-heavy, drain-heavy and balanced traffic so full and empty both recur
	task automatic run_random(int unsigned n_items);
		int unsigned k;
		int unsigned push_pct;
		int unsigned r;
		op_t beat_op;
		push_pct = 50;
		for (k = 0; k < n_items; k++) begin
			if (k % 40 == 0) begin
				case ($urandom_range(2))
					0: push_pct = 75;
					1: push_pct = 15;
					default: push_pct = 45;
				endcase
			end
			r = $urandom_range(99);
			if (r < push_pct) beat_op = OP_PUSH;
			else begin
				case ($urandom_range(4))
					0, 1: beat_op = OP_POP;
					2, 3: beat_op = OP_REMOVE_MID;
					default: beat_op = OP_PEEK;
				endcase
			end
			send_beat(beat_op, pick_value());
		end
	endtask

	initial begin
		int unsigned k;
		mirror = new();
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// operations on an empty stack
		send_beat(OP_PEEK, VAL_MAX);
		send_beat(OP_POP, '0);
		send_beat(OP_REMOVE_MID, '1);
		// single entry removed as the middle
		send_beat(OP_PUSH, VAL_MAX);
		send_beat(OP_REMOVE_MID, VAL_MIN);
		// fill up, then push on full
		send_beat(OP_PUSH, VAL_MIN);
		send_beat(OP_PUSH, '1);
		send_beat(OP_PUSH, '0);
		send_beat(OP_PUSH, VAL_MAX);
		for (k = 4; k < STACK_DEPTH; k++) send_beat(OP_PUSH, $urandom);
		send_beat(OP_PUSH, 32'sh5a5a_a5a5);
		send_beat(OP_PEEK, '0);
		send_beat(OP_REMOVE_MID, '0);
		send_beat(OP_POP, '0);

		run_random(400);

		// long hold-off at the output while beats keep coming
		hold_req = 1'b1;
		run_random(40);
		while (hold_req) @(posedge clk);

		// sender pause until everything is back
		wait_drained();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		run_random(300);
		tx_idle_pct = 36;
		rx_idle_pct = 36;

		run_random(400);

		wait_drained();
		repeat (20) @(posedge clk);
		if (mirror.mismatches == 0 && mirror.outstanding() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
